// ----- src/wcts_pkg.sv -----
// Shared types and constants for the weighted class thread scheduler.
// No dependencies; used by the top level.
package wcts_pkg;

    typedef enum logic [2:0] {
        OP_ENQ   = 3'd0,
        OP_WAKE  = 3'd1,
        OP_SETC  = 3'd2,
        OP_YIELD = 3'd3,
        OP_BLOCK = 3'd4,
        OP_TICK  = 3'd5,
        OP_IRQX  = 3'd6
    } op_t;

    localparam logic [1:0] STS_DONE   = 2'd0;
    localparam logic [1:0] STS_IGN    = 2'd1;
    localparam logic [1:0] STS_QUEUED = 2'd2;
    localparam logic [1:0] STS_IDLE   = 2'd3;

    localparam logic [1:0] TS_BLOCKED = 2'd0;
    localparam logic [1:0] TS_READY   = 2'd1;
    localparam logic [1:0] TS_RUNNING = 2'd2;

    localparam logic [2:0] CFG_WMODE   = 3'd0;
    localparam logic [2:0] CFG_PREEMPT = 3'd1;
    localparam logic [2:0] CFG_SL_INT  = 3'd2;
    localparam logic [2:0] CFG_SL_LAT  = 3'd3;
    localparam logic [2:0] CFG_SL_THR  = 3'd4;
    localparam logic [2:0] CFG_SL_BG   = 3'd5;

    localparam logic [3:0] PAT_LAST = 4'd12;

    // per-thread attributes kept in one memory word
    typedef struct packed {
        logic [1:0] st;
        logic [1:0] cls;
        logic       q;
    } attr_t;

    // 13-slot weighted pattern: 6 interactive, 4 latency, 2 throughput, 1 background
    function automatic logic [1:0] pat_class(input logic [3:0] idx);
        logic [1:0] c;
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: c = 2'd0;
            4'd6, 4'd7, 4'd8, 4'd9:             c = 2'd1;
            4'd10, 4'd11:                       c = 2'd2;
            default:                            c = 2'd3;
        endcase
        return c;
    endfunction

endpackage

// ----- src/wcts_ram.sv -----
// Simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module wcts_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 6
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/weighted_class_thread_scheduler.sv -----
// Weighted class thread scheduler: one item at a time, one result per item.
// The time an item takes is set by the queue walk of a class change (one link
// per cycle) and the pattern scan (one slot per cycle, over the 13-slot pattern).
// The next item is taken the cycle after the result is registered;
// a result held by m_ready adds its wait.
// After reset a clearing pass writes the attributes of all MAX_THREADS threads;
// no item is accepted during it. Depends on wcts_pkg and wcts_ram.
module weighted_class_thread_scheduler #(
    parameter int MAX_THREADS = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [3:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_op,
    input  logic [5:0] s_thread_id,
    input  logic [1:0] s_new_class,
    input  logic       s_can_preempt,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [5:0] m_current_thread,
    output logic       m_switched,
    output logic       m_need_resched,
    output logic [1:0] m_status,
    output logic [1:0] m_picked_class
);

    localparam int IW = $clog2(MAX_THREADS);
    localparam int AW = $bits(wcts_pkg::attr_t);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DEC, S_UL_START, S_UL_WAIT, S_UL_FIX,
        S_APP, S_APP_WAIT, S_APP_W2, S_PICK, S_SCAN, S_POP, S_POP_WAIT,
        S_POP_W, S_DISP, S_DISP2, S_FIN
    } state_t;

    state_t state_reg;

    logic       wmode_reg, preempt_reg;
    logic [3:0] sl_int_reg, sl_lat_reg, sl_thr_reg, sl_bg_reg;

    wcts_pkg::op_t op_reg;
    logic [IW-1:0] t_reg, prev_reg, running_reg, clr_reg;
    logic [IW-1:0] app_t_reg, wprev_reg, wcur_reg, hd_reg;
    logic [1:0]    ncls_reg, cls_reg, app_c_reg, pc_reg, run_cls_reg, status_reg;
    logic          ok_reg;
    logic [3:0]    nonempty_reg;
    logic [IW-1:0] tail_reg [4];
    logic [3:0]    cursor_reg, scan_reg, budget_reg, used_reg;
    logic          resched_reg;

    logic          m_valid_reg, m_switched_reg, m_resched_reg;
    logic [5:0]    m_cur_reg;
    logic [1:0]    m_status_reg, m_cls_reg;

    // memory ports
    logic          a_we, l_we;
    logic [IW-1:0] a_waddr, a_raddr, l_waddr, l_raddr, l_wdata, rdl;
    wcts_pkg::attr_t a_wdata, rda;
    logic [AW-1:0] rda_raw;

    wcts_ram #(.DEPTH(MAX_THREADS), .WIDTH(AW)) u_attr (
        .aclk(aclk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(a_raddr), .rdata(rda_raw)
    );

    wcts_ram #(.DEPTH(MAX_THREADS), .WIDTH(IW)) u_link (
        .aclk(aclk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(rdl)
    );

    assign rda = wcts_pkg::attr_t'(rda_raw);

    function automatic logic [3:0] slice_of(input logic [1:0] c);
        logic [3:0] s;
        case (c)
            2'd0:    s = sl_int_reg;
            2'd1:    s = sl_lat_reg;
            2'd2:    s = sl_thr_reg;
            default: s = sl_bg_reg;
        endcase
        return s;
    endfunction

    logic [1:0] strict_c;
    always_comb begin
        if (nonempty_reg[0])      strict_c = 2'd0;
        else if (nonempty_reg[1]) strict_c = 2'd1;
        else if (nonempty_reg[2]) strict_c = 2'd2;
        else                      strict_c = 2'd3;
    end

    logic          accept, tid_ok;
    logic [IW-1:0] tid;
    logic [3:0]    used_inc;
    logic [3:0]    scan_nx;
    logic [1:0]    scan_c;
    logic          was_queued;

    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;
    assign tid_ok     = 32'(s_thread_id) < MAX_THREADS;
    assign tid        = IW'(s_thread_id);
    assign used_inc   = (used_reg == 4'd15) ? 4'd15 : used_reg + 4'd1;
    assign scan_nx    = (scan_reg == wcts_pkg::PAT_LAST) ? 4'd0 : scan_reg + 4'd1;
    assign scan_c     = wcts_pkg::pat_class(scan_reg);
    assign was_queued = (rda.st == wcts_pkg::TS_READY) && rda.q;

    // memory read and write ports follow the sequencer state
    always_comb begin
        a_we    = 1'b0;
        a_waddr = t_reg;
        a_wdata = '{st: wcts_pkg::TS_READY, cls: app_c_reg, q: 1'b1};
        a_raddr = tid;
        l_we    = 1'b0;
        l_waddr = app_t_reg;
        l_wdata = app_t_reg;
        l_raddr = rdl;
        case (state_reg)
            S_CLEAR: begin
                a_we    = 1'b1;
                a_waddr = clr_reg;
                a_wdata = '{st: (clr_reg == '0) ? wcts_pkg::TS_RUNNING : wcts_pkg::TS_BLOCKED,
                            cls: 2'd0, q: 1'b0};
            end
            S_DEC: begin
                if (op_reg == wcts_pkg::OP_SETC && ok_reg && rda.cls != ncls_reg
                        && !was_queued) begin
                    a_we    = 1'b1;
                    a_wdata = '{st: rda.st, cls: ncls_reg, q: rda.q};
                end
            end
            S_UL_START: l_raddr = tail_reg[cls_reg];
            S_UL_FIX: begin
                l_we    = 1'b1;
                l_waddr = wprev_reg;
                l_wdata = rdl;
            end
            S_APP: begin
                a_we    = 1'b1;
                a_waddr = app_t_reg;
                l_raddr = tail_reg[app_c_reg];
                l_we    = !nonempty_reg[app_c_reg];
            end
            S_APP_WAIT: begin
                l_we    = 1'b1;
                l_wdata = rdl;
            end
            S_APP_W2: begin
                l_we    = 1'b1;
                l_waddr = tail_reg[app_c_reg];
            end
            S_POP: l_raddr = tail_reg[pc_reg];
            S_POP_W: begin
                l_we    = 1'b1;
                l_waddr = tail_reg[pc_reg];
                l_wdata = rdl;
            end
            S_DISP: begin
                if (op_reg == wcts_pkg::OP_BLOCK) begin
                    a_we    = 1'b1;
                    a_waddr = running_reg;
                    a_wdata = '{st: wcts_pkg::TS_BLOCKED, cls: run_cls_reg, q: 1'b0};
                end
            end
            S_DISP2: begin
                a_we    = 1'b1;
                a_waddr = hd_reg;
                a_wdata = '{st: wcts_pkg::TS_RUNNING, cls: pc_reg, q: 1'b0};
            end
            default: ;
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wmode_reg   <= 1'b1;
            preempt_reg <= 1'b1;
            sl_int_reg  <= 4'd2;
            sl_lat_reg  <= 4'd3;
            sl_thr_reg  <= 4'd5;
            sl_bg_reg   <= 4'd8;
        end else if (cfg_we) begin
            case (cfg_index)
                wcts_pkg::CFG_WMODE:   wmode_reg   <= cfg_wdata[0];
                wcts_pkg::CFG_PREEMPT: preempt_reg <= cfg_wdata[0];
                wcts_pkg::CFG_SL_INT:  sl_int_reg  <= cfg_wdata;
                wcts_pkg::CFG_SL_LAT:  sl_lat_reg  <= cfg_wdata;
                wcts_pkg::CFG_SL_THR:  sl_thr_reg  <= cfg_wdata;
                wcts_pkg::CFG_SL_BG:   sl_bg_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            nonempty_reg <= '0;
            running_reg  <= '0;
            run_cls_reg  <= 2'd0;
            cursor_reg   <= 4'd0;
            budget_reg   <= 4'd0;
            used_reg     <= 4'd0;
            resched_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == IW'(MAX_THREADS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        op_reg     <= wcts_pkg::op_t'(s_op);
                        t_reg      <= tid;
                        ok_reg     <= tid_ok;
                        ncls_reg   <= s_new_class;
                        prev_reg   <= running_reg;
                        status_reg <= wcts_pkg::STS_DONE;
                        app_t_reg  <= running_reg;
                        app_c_reg  <= run_cls_reg;
                        case (s_op)
                            wcts_pkg::OP_ENQ, wcts_pkg::OP_WAKE, wcts_pkg::OP_SETC:
                                state_reg <= S_DEC;
                            wcts_pkg::OP_YIELD: begin
                                resched_reg <= 1'b0;
                                state_reg   <= (running_reg != '0) ? S_APP : S_PICK;
                            end
                            wcts_pkg::OP_BLOCK: begin
                                if (running_reg == '0) begin
                                    status_reg <= wcts_pkg::STS_IDLE;
                                    state_reg  <= S_FIN;
                                end else begin
                                    state_reg <= S_PICK;
                                end
                            end
                            wcts_pkg::OP_TICK: begin
                                if (preempt_reg) begin
                                    used_reg <= used_inc;
                                    if (budget_reg == 4'd0 || used_inc >= budget_reg) begin
                                        resched_reg <= 1'b1;
                                    end
                                end
                                state_reg <= S_FIN;
                            end
                            wcts_pkg::OP_IRQX: begin
                                if (preempt_reg && resched_reg && s_can_preempt) begin
                                    resched_reg <= 1'b0;
                                    state_reg   <= (running_reg != '0) ? S_APP : S_PICK;
                                end else begin
                                    state_reg <= S_FIN;
                                end
                            end
                            default: begin
                                status_reg <= wcts_pkg::STS_IGN;
                                state_reg  <= S_FIN;
                            end
                        endcase
                    end
                end
                S_DEC: begin
                    app_t_reg <= t_reg;
                    app_c_reg <= rda.cls;
                    cls_reg   <= rda.cls;
                    state_reg <= S_FIN;
                    if (op_reg == wcts_pkg::OP_SETC) begin
                        if (!ok_reg) begin
                            status_reg <= wcts_pkg::STS_IGN;
                        end else if (rda.cls != ncls_reg) begin
                            if (t_reg == running_reg) begin
                                run_cls_reg <= ncls_reg;
                            end
                            if (was_queued) begin
                                state_reg <= S_UL_START;
                            end
                        end
                    end else if (!ok_reg || t_reg == '0 || t_reg == running_reg
                            || (op_reg == wcts_pkg::OP_WAKE
                                && rda.st != wcts_pkg::TS_BLOCKED)) begin
                        status_reg <= wcts_pkg::STS_IGN;
                    end else if (rda.q) begin
                        status_reg <= wcts_pkg::STS_QUEUED;
                    end else begin
                        state_reg <= S_APP;
                    end
                end
                S_UL_START: begin
                    app_c_reg <= ncls_reg;
                    wprev_reg <= tail_reg[cls_reg];
                    state_reg <= nonempty_reg[cls_reg] ? S_UL_WAIT : S_APP;
                end
                S_UL_WAIT: begin
                    // rdl is the link that follows wprev
                    if (rdl == t_reg) begin
                        if (rdl == wprev_reg) begin
                            nonempty_reg[cls_reg] <= 1'b0;
                            state_reg <= S_APP;
                        end else begin
                            wcur_reg  <= rdl;
                            state_reg <= S_UL_FIX;
                        end
                    end else if (rdl == tail_reg[cls_reg]) begin
                        state_reg <= S_APP;
                    end else begin
                        wprev_reg <= rdl;
                    end
                end
                S_UL_FIX: begin
                    if (tail_reg[cls_reg] == wcur_reg) begin
                        tail_reg[cls_reg] <= wprev_reg;
                    end
                    state_reg <= S_APP;
                end
                S_APP: begin
                    if (!nonempty_reg[app_c_reg]) begin
                        nonempty_reg[app_c_reg] <= 1'b1;
                        tail_reg[app_c_reg]     <= app_t_reg;
                        state_reg <= (op_reg == wcts_pkg::OP_YIELD
                                      || op_reg == wcts_pkg::OP_IRQX) ? S_PICK : S_FIN;
                    end else begin
                        state_reg <= S_APP_WAIT;
                    end
                end
                S_APP_WAIT: state_reg <= S_APP_W2;
                S_APP_W2: begin
                    tail_reg[app_c_reg] <= app_t_reg;
                    state_reg <= (op_reg == wcts_pkg::OP_YIELD
                                  || op_reg == wcts_pkg::OP_IRQX) ? S_PICK : S_FIN;
                end
                S_PICK: begin
                    if (nonempty_reg == '0) begin
                        // nothing ready: current thread stays
                        if (op_reg == wcts_pkg::OP_BLOCK) begin
                            status_reg <= wcts_pkg::STS_IGN;
                        end else begin
                            budget_reg <= slice_of(run_cls_reg);
                            used_reg   <= 4'd0;
                        end
                        state_reg <= S_FIN;
                    end else if (wmode_reg) begin
                        scan_reg  <= cursor_reg;
                        state_reg <= S_SCAN;
                    end else begin
                        pc_reg    <= strict_c;
                        state_reg <= S_POP;
                    end
                end
                S_SCAN: begin
                    if (nonempty_reg[scan_c]) begin
                        pc_reg     <= scan_c;
                        cursor_reg <= scan_nx;
                        state_reg  <= S_POP;
                    end else begin
                        scan_reg <= scan_nx;
                    end
                end
                S_POP: state_reg <= S_POP_WAIT;
                S_POP_WAIT: begin
                    hd_reg <= rdl;
                    if (rdl == tail_reg[pc_reg]) begin
                        nonempty_reg[pc_reg] <= 1'b0;
                        state_reg <= S_DISP;
                    end else begin
                        state_reg <= S_POP_W;
                    end
                end
                S_POP_W: state_reg <= S_DISP;
                S_DISP:  state_reg <= S_DISP2;
                S_DISP2: begin
                    running_reg <= hd_reg;
                    run_cls_reg <= pc_reg;
                    budget_reg  <= slice_of(pc_reg);
                    used_reg    <= 4'd0;
                    state_reg   <= S_FIN;
                end
                S_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_cur_reg      <= 6'(running_reg);
                        m_switched_reg <= running_reg != prev_reg;
                        m_resched_reg  <= resched_reg;
                        m_status_reg   <= status_reg;
                        m_cls_reg      <= run_cls_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_current_thread = m_cur_reg;
    assign m_switched       = m_switched_reg;
    assign m_need_resched   = m_resched_reg;
    assign m_status         = m_status_reg;
    assign m_picked_class   = m_cls_reg;

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in flight");

    a_idle_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == wcts_pkg::STS_IDLE |-> m_current_thread == 6'd0 && !m_switched)
        else $error("idle block result inconsistent");

    a_switch_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_switched |-> m_status == wcts_pkg::STS_DONE)
        else $error("switch reported with non-done status");

endmodule
